/* hdl/mcvt_pkg.sv */
// Shared types, constants and command codes for the chord voice transition block.
// No dependencies; the top level, mcvt_match and mcvt_fmt refer to this package by scoped names.
package mcvt_pkg;

  // Chord slots held by the block (1..4).
  localparam int MAX_CHORD = 4;
  localparam int SLOT_W    = (MAX_CHORD > 1) ? $clog2(MAX_CHORD) : 1;

  // Field widths fixed by the message format.
  localparam int NOTE_W = 7;
  localparam int CNT_W  = 3;
  localparam int CH_W   = 5;
  localparam int KIND_W = 3;
  localparam int TIME_W = 16;

  localparam logic [CH_W-1:0] CHAN_MAX = CH_W'(16);

  // Command kinds.
  localparam logic [KIND_W-1:0] K_RETRIG  = 3'd0;
  localparam logic [KIND_W-1:0] K_LEGATO  = 3'd1;
  localparam logic [KIND_W-1:0] K_SILENCE = 3'd2;
  localparam logic [KIND_W-1:0] K_PANIC   = 3'd3;
  localparam logic [KIND_W-1:0] K_OBSERVE = 3'd4;

  // MIDI status nibbles and controller numbers.
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_CTRL     = 8'hB0;
  localparam logic [3:0] SYS_NIBBLE  = 4'hF;
  localparam logic [NOTE_W-1:0] CC_ALL_NOTES_OFF = 7'd123;
  localparam logic [NOTE_W-1:0] CC_ALL_SOUND_OFF = 7'd120;

  typedef logic [NOTE_W-1:0] note_t;
  typedef note_t [MAX_CHORD-1:0] notes_t;

  // Message type selected by the sequencer.
  typedef enum logic [1:0] {
    MT_OFF,
    MT_ON,
    MT_CTRL
  } msg_type_t;

  // One message request from the sequencer to the formatter.
  typedef struct packed {
    msg_type_t         mtype;
    logic [CH_W-1:0]   chan;   // 1..16
    note_t             data1;
    logic [NOTE_W-1:0] vel;
  } msg_req_t;

endpackage

/* hdl/midi_chord_voice_transition_top.sv */
// Top level of the chord voice transition block: command latch, chord state,
// message sequencer and output register. Depends on mcvt_pkg, mcvt_match, mcvt_fmt.
//
//  channel   | signals                                        | flow
//  ----------+------------------------------------------------+---------------------------
//  command   | start, busy, kind .. event_time                | taken when start & !busy
//  config    | cfg_valid, cfg_ready, cfg_data                 | written when valid & ready
//  messages  | msg_valid, msg_status .. msg_time, last        | one-cycle strobe, no stall
//
// After the accept edge busy stays high through the off steps over the old chord, then
// the note-on steps over the new chord (retrigger, legato) or the controller steps
// (panic), then the flush step; silence runs the off steps and the flush step, status-byte
// and unused commands only the flush step. The shared compare unit serves one candidate
// message per step. Each message waits in a one-entry holding register until the next
// one or the flush step, so the last one carries last; the message side never stalls.
// Synchronous active-high reset clears the chord (count zero) and sets both channels to 1.
module midi_chord_voice_transition_top (
  input  logic                              clk,
  input  logic                              rst,
  // command
  input  logic                              start,
  output logic                              busy,
  input  logic [mcvt_pkg::KIND_W-1:0]       kind,
  input  logic                              chord_valid,
  input  logic [mcvt_pkg::NOTE_W-1:0]       note_a,
  input  logic [mcvt_pkg::NOTE_W-1:0]       note_b,
  input  logic [mcvt_pkg::NOTE_W-1:0]       note_c,
  input  logic [mcvt_pkg::NOTE_W-1:0]       note_d,
  input  logic [mcvt_pkg::CNT_W-1:0]        chord_size,
  input  logic [mcvt_pkg::NOTE_W-1:0]       chord_velocity,
  input  logic [7:0]                        status_byte,
  input  logic [mcvt_pkg::TIME_W-1:0]       event_time,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcvt_pkg::CH_W-1:0]         cfg_data,
  // messages
  output logic                              msg_valid,
  output logic [7:0]                        msg_status,
  output logic [mcvt_pkg::NOTE_W-1:0]       msg_data1,
  output logic [mcvt_pkg::NOTE_W-1:0]       msg_data2,
  output logic [mcvt_pkg::TIME_W-1:0]       msg_time,
  output logic                              last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFFS  = 3'd1;
  localparam logic [2:0] S_ONS   = 3'd2;
  localparam logic [2:0] S_CC    = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  localparam logic [mcvt_pkg::CNT_W-1:0] CC_LAST = mcvt_pkg::CNT_W'(3);

  logic [2:0] state, state_next;
  logic [mcvt_pkg::CNT_W-1:0] idx, idx_next;
  logic [mcvt_pkg::SLOT_W-1:0] slot;

  // Chord state
  mcvt_pkg::notes_t              sounding_notes;
  logic [mcvt_pkg::CNT_W-1:0]    sounding_count;
  logic [mcvt_pkg::CH_W-1:0]     sounding_channel;
  logic [mcvt_pkg::CH_W-1:0]     input_channel;
  logic [mcvt_pkg::CH_W-1:0]     chan_cfg;

  // Latched command
  logic [mcvt_pkg::KIND_W-1:0]   kind_r;
  logic [mcvt_pkg::CNT_W-1:0]    cnt_r;
  logic [mcvt_pkg::NOTE_W-1:0]   vel_r;
  logic [mcvt_pkg::TIME_W-1:0]   time_r;
  logic [mcvt_pkg::CH_W-1:0]     tgt_r;
  mcvt_pkg::notes_t              next_r;

  // Accept-side decode
  logic                          accept;
  logic [mcvt_pkg::KIND_W-1:0]   kind_eff;
  logic [mcvt_pkg::CNT_W-1:0]    cnt_sat;
  logic [mcvt_pkg::NOTE_W-1:0]   vel_sat;
  logic [mcvt_pkg::CH_W-1:0]     tgt_ch;
  mcvt_pkg::note_t [3:0]         in_notes;

  // Shared compare unit and message path
  mcvt_pkg::note_t               m_probe;
  mcvt_pkg::notes_t              m_set;
  logic [mcvt_pkg::CNT_W-1:0]    m_count;
  logic                          m_hit;
  logic                          gen;
  mcvt_pkg::msg_req_t            req;
  logic [7:0]                    f_status;
  logic [mcvt_pkg::NOTE_W-1:0]   f_data2;

  logic                          pend_valid;
  logic [7:0]                    pend_status;
  logic [mcvt_pkg::NOTE_W-1:0]   pend_data1;
  logic [mcvt_pkg::NOTE_W-1:0]   pend_data2;

  assign busy      = (state != S_IDLE);
  // register writes never share an edge with a command
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign slot      = idx[mcvt_pkg::SLOT_W-1:0];
  assign in_notes  = {note_d, note_c, note_b, note_a};

  // Command decode at accept
  always_comb begin
    kind_eff = kind;
    if (((kind == mcvt_pkg::K_RETRIG) || (kind == mcvt_pkg::K_LEGATO)) && !chord_valid) begin
      kind_eff = mcvt_pkg::K_SILENCE;
    end
    cnt_sat = (chord_size > mcvt_pkg::CNT_W'(mcvt_pkg::MAX_CHORD)) ?
              mcvt_pkg::CNT_W'(mcvt_pkg::MAX_CHORD) : chord_size;
    vel_sat = (chord_velocity == '0) ? mcvt_pkg::NOTE_W'(1) : chord_velocity;
    if (chan_cfg == '0) begin
      tgt_ch = input_channel;
    end else if (chan_cfg > mcvt_pkg::CHAN_MAX) begin
      tgt_ch = mcvt_pkg::CHAN_MAX;
    end else begin
      tgt_ch = chan_cfg;
    end
  end

  // Compare unit operand select: offs probe the old chord against the new one,
  // ons probe the new chord against the old one.
  always_comb begin
    if (state == S_OFFS) begin
      m_probe = sounding_notes[slot];
      m_set   = next_r;
      m_count = cnt_r;
    end else begin
      m_probe = next_r[slot];
      m_set   = sounding_notes;
      m_count = sounding_count;
    end
  end

  mcvt_match u_match (
    .probe (m_probe),
    .set   (m_set),
    .count (m_count),
    .hit   (m_hit)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    gen        = 1'b0;
    req.mtype  = mcvt_pkg::MT_OFF;
    req.chan   = sounding_channel;
    req.data1  = sounding_notes[slot];
    req.vel    = vel_r;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          case (kind_eff) inside
            mcvt_pkg::K_RETRIG, mcvt_pkg::K_LEGATO, mcvt_pkg::K_SILENCE,
            mcvt_pkg::K_PANIC: state_next = S_OFFS;
            default:           state_next = S_FLUSH;
          endcase
        end
      end
      S_OFFS: begin
        if (idx < sounding_count) begin
          gen      = (kind_r != mcvt_pkg::K_LEGATO) || !m_hit;
          idx_next = idx + mcvt_pkg::CNT_W'(1);
        end else begin
          idx_next = '0;
          case (kind_r) inside
            mcvt_pkg::K_RETRIG, mcvt_pkg::K_LEGATO: state_next = S_ONS;
            mcvt_pkg::K_PANIC:                      state_next = S_CC;
            default:                                state_next = S_FLUSH;
          endcase
        end
      end
      S_ONS: begin
        req.mtype = mcvt_pkg::MT_ON;
        req.chan  = tgt_r;
        req.data1 = next_r[slot];
        if (idx < cnt_r) begin
          gen      = (kind_r == mcvt_pkg::K_RETRIG) || !m_hit;
          idx_next = idx + mcvt_pkg::CNT_W'(1);
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_CC: begin
        // Steps 0/1 on the sounding channel, 2/3 on the target channel if it differs.
        req.mtype = mcvt_pkg::MT_CTRL;
        req.chan  = idx[1] ? tgt_r : sounding_channel;
        req.data1 = idx[0] ? mcvt_pkg::CC_ALL_SOUND_OFF : mcvt_pkg::CC_ALL_NOTES_OFF;
        gen       = !idx[1] || (tgt_r != sounding_channel);
        idx_next  = idx + mcvt_pkg::CNT_W'(1);
        if (idx == CC_LAST) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  mcvt_fmt u_fmt (
    .req    (req),
    .status (f_status),
    .data2  (f_data2)
  );

  // Control registers and chord state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      idx              <= '0;
      sounding_count   <= '0;
      sounding_channel <= mcvt_pkg::CH_W'(1);
      input_channel    <= mcvt_pkg::CH_W'(1);
      chan_cfg         <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_valid && cfg_ready) begin
        chan_cfg <= cfg_data;
      end
      if (accept && (kind_eff == mcvt_pkg::K_OBSERVE) &&
          (status_byte[7:4] != mcvt_pkg::SYS_NIBBLE)) begin
        input_channel <= mcvt_pkg::CH_W'(status_byte[3:0]) + mcvt_pkg::CH_W'(1);
      end
      if (state == S_FLUSH) begin
        case (kind_r) inside
          mcvt_pkg::K_RETRIG, mcvt_pkg::K_LEGATO: begin
            sounding_count   <= cnt_r;
            sounding_channel <= tgt_r;
          end
          mcvt_pkg::K_SILENCE, mcvt_pkg::K_PANIC: sounding_count <= '0;
          default: ;
        endcase
      end
    end
  end

  // Command latch and note store
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_eff;
      cnt_r  <= cnt_sat;
      vel_r  <= vel_sat;
      time_r <= event_time;
      tgt_r  <= tgt_ch;
      for (int i = 0; i < mcvt_pkg::MAX_CHORD; i++) begin
        next_r[i] <= in_notes[i];
      end
    end
    if ((state == S_FLUSH) &&
        ((kind_r == mcvt_pkg::K_RETRIG) || (kind_r == mcvt_pkg::K_LEGATO))) begin
      sounding_notes <= next_r;
    end
  end

  // Holding register and output strobe control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      msg_valid  <= 1'b0;
      last       <= 1'b0;
    end else begin
      msg_valid <= 1'b0;
      last      <= 1'b0;
      if (state == S_FLUSH) begin
        msg_valid  <= pend_valid;
        last       <= pend_valid;
        pend_valid <= 1'b0;
      end else if (gen) begin
        msg_valid  <= pend_valid;
        pend_valid <= 1'b1;
      end
    end
  end

  // Message payload
  always_ff @(posedge clk) begin
    if ((state == S_FLUSH) || gen) begin
      msg_status <= pend_status;
      msg_data1  <= pend_data1;
      msg_data2  <= pend_data2;
      msg_time   <= time_r;
    end
    if (gen) begin
      pend_status <= f_status;
      pend_data1  <= req.data1;
      pend_data2  <= f_data2;
    end
  end

endmodule

/* hdl/mcvt_match.sv */
// Shared compare unit: is a note present among the first count entries of a chord set.
// Depends on mcvt_pkg.
module mcvt_match (
  input  mcvt_pkg::note_t                probe,
  input  mcvt_pkg::notes_t               set,
  input  logic [mcvt_pkg::CNT_W-1:0]     count,
  output logic                           hit
);

  // Parallel equality over the slots, masked by the fill count.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < mcvt_pkg::MAX_CHORD; i++) begin
      if ((mcvt_pkg::CNT_W'(i) < count) && (set[i] == probe)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

/* hdl/mcvt_fmt.sv */
// Message formatter: builds the MIDI status byte and second data byte of one request.
// Depends on mcvt_pkg.
module mcvt_fmt (
  input  mcvt_pkg::msg_req_t             req,
  output logic [7:0]                     status,
  output logic [mcvt_pkg::NOTE_W-1:0]    data2
);

  logic [mcvt_pkg::CH_W-1:0] chan_idx;
  logic [7:0]                base;

  assign chan_idx = req.chan - mcvt_pkg::CH_W'(1);

  // Status nibble by type; velocity only on note-on.
  always_comb begin
    unique case (req.mtype)
      mcvt_pkg::MT_ON: begin
        base  = mcvt_pkg::ST_NOTE_ON;
        data2 = req.vel;
      end
      mcvt_pkg::MT_CTRL: begin
        base  = mcvt_pkg::ST_CTRL;
        data2 = '0;
      end
      default: begin
        base  = mcvt_pkg::ST_NOTE_OFF;
        data2 = '0;
      end
    endcase
  end

  assign status = base | {4'b0, chan_idx[3:0]};

endmodule

/* hdl/mcvt_checker.sv */
// Port-level checker for the chord voice transition top level, with its bind.
// Depends only on the top level's ports.
module mcvt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       msg_valid,
  input logic [7:0] msg_status,
  input logic [6:0] msg_data2,
  input logic       last
);

  // An accepted command always makes the block busy from the cycle after its acceptance.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command accepted but block not busy");

  // More messages follow a non-final one, so the command is still in flight.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !last |-> busy)
    else $error("non-final message while idle");

  // The final message is never directly followed by another.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    msg_valid && last |=> !msg_valid)
    else $error("message right after final message");

  // Only note-ons carry a nonzero second byte; every status has bit 7 set.
  a_data2: assert property (@(posedge clk) disable iff (rst)
    msg_valid |-> msg_status[7] && (msg_data2 == 7'd0 || msg_status[7:4] == 4'h9))
    else $error("bad status or second data byte");

  // Configuration is only taken while no command is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !busy)
    else $error("configuration write while busy");

endmodule

bind midi_chord_voice_transition_top mcvt_checker u_mcvt_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .msg_valid  (msg_valid),
  .msg_status (msg_status),
  .msg_data2  (msg_data2),
  .last       (last)
);
